### rtl/core/ntt_pkg.sv
// ----------------------------------------------------------------------------
// ntt_pkg
// shared types, constants and the octave root table of the note tuning table
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int DefNumNotes = 128;

  localparam int NoteW  = 7;
  localparam int CentsW = 18;
  localparam int FreqW  = 32;
  localparam int AccW   = 32;
  localparam int ProdW  = 64;
  localparam int RemW   = 21;
  localparam int TW     = RemW + 1;
  localparam int FRemW  = 17;
  localparam int QW     = 5;
  localparam int StepW  = 5;
  localparam int MW     = 41;
  localparam int SW     = MW + 1;

  localparam int FracBits  = 24;
  localparam int QDivSteps = 5;

  localparam int Octave    = 120000;
  localparam int SemiCents = 10000;
  localparam int NoteStep  = 12;
  // biased octave index: -69 semitones plus 10 octaves
  localparam int TBias     = 510000;
  // right shift is 15 - q with q = biased q - 10
  localparam int KBase     = 25;
  localparam int MulRef    = 440;
  localparam int RndHalf   = 1 << 30;

  localparam logic ModeUpdate = 1'b0;
  localparam logic ModeQuery  = 1'b1;

  typedef logic [FracBits-1:0][AccW-1:0] root_tbl_t;

  typedef struct packed {
    logic             load;
    logic             rd;
    logic             wr;
    logic             tsum;
    logic             qdiv;
    logic             fmul;
    logic             facc;
    logic             scale;
    logic             clr;
    logic             out_load;
    logic [StepW-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic is_update;
    logic note_ok;
    logic upd_last;
  } sts_t;

  function automatic logic [AccW-1:0] isqrt_u64(logic [ProdW-1:0] x);
    logic [ProdW-1:0] rem_v;
    logic [ProdW-1:0] res_v;
    logic [ProdW-1:0] bit_v;
    int i;
    rem_v = x;
    res_v = '0;
    bit_v = {2'b01, {(ProdW-2){1'b0}}};
    for (i = 0; i < ProdW / 2; i++) begin
      if (rem_v >= res_v + bit_v) begin
        rem_v = rem_v - (res_v + bit_v);
        res_v = (res_v >> 1) + bit_v;
      end else begin
        res_v = res_v >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res_v[AccW-1:0];
  endfunction

  // entry i holds 2^(1/2^(i+1)) in q1.31, each one the floor root of the last
  function automatic root_tbl_t calc_roots();
    root_tbl_t        tbl;
    logic [ProdW-1:0] r;
    int i;
    r = ProdW'(2) << 31;
    for (i = 0; i < FracBits; i++) begin
      r = {{(ProdW-AccW){1'b0}}, isqrt_u64(r << 31)};
      tbl[i] = r[AccW-1:0];
    end
    return tbl;
  endfunction

  localparam root_tbl_t Roots = calc_roots();

endpackage

### rtl/core/ntt_ram.sv
// ----------------------------------------------------------------------------
// ntt_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module ntt_ram #(
  parameter int Width = 18,
  parameter int Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/ntt_dpath.sv
// ----------------------------------------------------------------------------
// ntt_dpath
// note table, octave division, fractional power of two and output register
// ----------------------------------------------------------------------------
module ntt_dpath #(
  parameter int NUM_NOTES = ntt_pkg::DefNumNotes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ntt_pkg::cmd_t                     cmd_i,
  output ntt_pkg::sts_t                     sts_o,
  input  logic                              mode_i,
  input  logic [ntt_pkg::NoteW-1:0]         note_i,
  input  logic signed [ntt_pkg::CentsW-1:0] cents_offset_i,
  input  logic                              cfg_wr_en_i,
  input  logic signed [ntt_pkg::CentsW-1:0] cfg_wr_data_i,
  output logic [ntt_pkg::FreqW-1:0]         frequency_o,
  output logic signed [ntt_pkg::CentsW-1:0] cents_deviation_o
);

  localparam int AW   = $clog2(NUM_NOTES);
  localparam int CntW = $clog2(NUM_NOTES + ntt_pkg::NoteStep);
  localparam int CmpW = ntt_pkg::NoteW + 2;

  logic                              mode_q;
  logic [ntt_pkg::NoteW-1:0]         note_q;
  logic [ntt_pkg::CentsW-1:0]        cents_q;
  logic [CntW-1:0]                   cnt_q;
  logic signed [ntt_pkg::CentsW-1:0] ref_q;
  logic [NUM_NOTES-1:0]              valid_q;
  logic                              vld_rd_q;
  logic [ntt_pkg::CentsW-1:0]        dev_q;
  logic [ntt_pkg::RemW-1:0]          rem_q;
  logic [ntt_pkg::QW-1:0]            qq_q;
  logic [ntt_pkg::AccW-1:0]          acc_q;
  logic [ntt_pkg::ProdW-1:0]         prod_q;
  logic [ntt_pkg::MW-1:0]            m_q;
  logic [ntt_pkg::FreqW-1:0]         freq_q;
  logic [ntt_pkg::CentsW-1:0]        devout_q;

  logic [AW-1:0]                     rd_addr;
  logic [ntt_pkg::CentsW-1:0]        ram_rdata;
  logic [ntt_pkg::CentsW-1:0]        cents_sel;
  logic [ntt_pkg::TW-1:0]            note_term;
  logic [ntt_pkg::TW-1:0]            t_sum;
  logic [ntt_pkg::RemW-1:0]          qdiv_sub;
  logic                              qdiv_ge;
  logic [ntt_pkg::FRemW:0]           rem2;
  logic                              frac_ge;
  logic [ntt_pkg::FRemW:0]           frac_rem;
  logic [ntt_pkg::AccW-1:0]          root;
  logic [ntt_pkg::ProdW-1:0]         prod_d;
  logic [ntt_pkg::ProdW-1:0]         acc_rnd;
  logic [ntt_pkg::MW-1:0]            m_d;
  logic [ntt_pkg::QW-1:0]            shamt;
  logic [ntt_pkg::SW-1:0]            rnd_sum;
  logic [ntt_pkg::SW-1:0]            shifted;
  logic [ntt_pkg::FreqW-1:0]         freq_d;

  assign rd_addr = AW'(note_q);

  ntt_ram #(
    .Width (ntt_pkg::CentsW),
    .Depth (NUM_NOTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (cents_q),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // never written entries read as equal temperament
  assign cents_sel = vld_rd_q ? ram_rdata : '0;

  assign note_term = ntt_pkg::TW'(note_q) * ntt_pkg::TW'(ntt_pkg::SemiCents);
  assign t_sum = note_term + ntt_pkg::TW'(ntt_pkg::TBias)
               + {{(ntt_pkg::TW-ntt_pkg::CentsW){cents_sel[ntt_pkg::CentsW-1]}}, cents_sel}
               + {{(ntt_pkg::TW-ntt_pkg::CentsW){ref_q[ntt_pkg::CentsW-1]}}, ref_q};

  assign qdiv_sub = ntt_pkg::RemW'(ntt_pkg::Octave)
                    << (3'(ntt_pkg::QDivSteps - 1) - cmd_i.step[2:0]);
  assign qdiv_ge  = rem_q >= qdiv_sub;

  assign rem2     = {rem_q[ntt_pkg::FRemW-1:0], 1'b0};
  assign frac_ge  = rem2 >= (ntt_pkg::FRemW+1)'(ntt_pkg::Octave);
  assign frac_rem = frac_ge ? rem2 - (ntt_pkg::FRemW+1)'(ntt_pkg::Octave) : rem2;
  assign root     = ntt_pkg::Roots[cmd_i.step];
  assign prod_d   = frac_ge ? ntt_pkg::ProdW'(acc_q) * ntt_pkg::ProdW'(root)
                            : {1'b0, acc_q, 31'b0};
  assign acc_rnd  = prod_q + ntt_pkg::ProdW'(ntt_pkg::RndHalf);

  assign m_d = ntt_pkg::MW'(acc_q) * ntt_pkg::MW'(ntt_pkg::MulRef);

  assign shamt   = ntt_pkg::QW'(ntt_pkg::KBase) - qq_q;
  assign rnd_sum = ntt_pkg::SW'(m_q) + (ntt_pkg::SW'(1) << (shamt - ntt_pkg::QW'(1)));
  assign shifted = rnd_sum >> shamt;
  assign freq_d  = (|shifted[ntt_pkg::SW-1:ntt_pkg::FreqW]) ? '1
                                                            : shifted[ntt_pkg::FreqW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q    <= '0;
      valid_q  <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        ref_q <= cfg_wr_data_i;
      end
      if (cmd_i.wr) begin
        valid_q[cnt_q[AW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q  <= mode_i;
      note_q  <= note_i;
      cents_q <= cents_offset_i;
      cnt_q   <= CntW'(note_i);
    end
    if (cmd_i.wr) begin
      cnt_q <= cnt_q + CntW'(ntt_pkg::NoteStep);
    end
    if (cmd_i.rd) begin
      vld_rd_q <= valid_q[rd_addr];
    end
    if (cmd_i.tsum) begin
      dev_q <= cents_sel;
      rem_q <= t_sum[ntt_pkg::RemW-1:0];
      qq_q  <= '0;
      acc_q <= ntt_pkg::AccW'(1) << (ntt_pkg::AccW - 1);
    end
    if (cmd_i.qdiv) begin
      rem_q <= qdiv_ge ? rem_q - qdiv_sub : rem_q;
      qq_q  <= {qq_q[ntt_pkg::QW-2:0], qdiv_ge};
    end
    if (cmd_i.fmul) begin
      rem_q  <= ntt_pkg::RemW'(frac_rem);
      prod_q <= prod_d;
    end
    if (cmd_i.facc) begin
      acc_q <= acc_rnd[62:31];
    end
    if (cmd_i.scale) begin
      m_q <= m_d;
    end
    if (cmd_i.clr) begin
      m_q   <= '0;
      qq_q  <= '0;
      dev_q <= '0;
    end
    if (cmd_i.out_load) begin
      freq_q   <= freq_d;
      devout_q <= dev_q;
    end
  end

  assign sts_o.is_update = (mode_q == ntt_pkg::ModeUpdate);
  assign sts_o.note_ok   = {2'b00, note_q} < CmpW'(NUM_NOTES);
  assign sts_o.upd_last  = (cnt_q + CntW'(ntt_pkg::NoteStep)) >= CntW'(NUM_NOTES);

  assign frequency_o       = freq_q;
  assign cents_deviation_o = devout_q;

  ap_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> (cnt_q < CntW'(NUM_NOTES)))
    else $error("table write beyond last note");

  ap_tsum_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tsum |-> $past(cmd_i.rd))
    else $error("exponent sum without a preceding table read");

endmodule

### rtl/core/ntt_ctrl.sv
// ----------------------------------------------------------------------------
// ntt_ctrl
// sequencer for table updates and frequency queries, owns the output valid
// ----------------------------------------------------------------------------
module ntt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  ntt_pkg::sts_t sts_i,
  output ntt_pkg::cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_UPD    = 4'd2;
  localparam logic [3:0] S_TSUM   = 4'd3;
  localparam logic [3:0] S_QDIV   = 4'd4;
  localparam logic [3:0] S_FMUL   = 4'd5;
  localparam logic [3:0] S_FACC   = 4'd6;
  localparam logic [3:0] S_SCALE  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                state_q, state_d;
  logic [ntt_pkg::StepW-1:0] step_q, step_d;
  logic                      out_valid_q, out_valid_d;
  logic                      in_accept;
  logic                      out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    cmd_o.step  = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.is_update) begin
          state_d = sts_i.note_ok ? S_UPD : S_IDLE;
        end else if (sts_i.note_ok) begin
          cmd_o.rd = 1'b1;
          state_d  = S_TSUM;
        end else begin
          cmd_o.clr = 1'b1;
          state_d   = S_OUT;
        end
      end
      S_UPD: begin
        cmd_o.wr = 1'b1;
        if (sts_i.upd_last) begin
          state_d = S_IDLE;
        end
      end
      S_TSUM: begin
        cmd_o.tsum = 1'b1;
        step_d     = '0;
        state_d    = S_QDIV;
      end
      S_QDIV: begin
        cmd_o.qdiv = 1'b1;
        if (step_q == ntt_pkg::StepW'(ntt_pkg::QDivSteps - 1)) begin
          step_d  = '0;
          state_d = S_FMUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      S_FMUL: begin
        cmd_o.fmul = 1'b1;
        state_d    = S_FACC;
      end
      S_FACC: begin
        cmd_o.facc = 1'b1;
        if (step_q == ntt_pkg::StepW'(ntt_pkg::FracBits - 1)) begin
          state_d = S_SCALE;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_FMUL;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ap_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == S_DECODE))
    else $error("accepted transaction not decoded");

  ap_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && out_stall_i) |=> (state_q == S_OUT))
    else $error("result dropped while output register busy");

  ap_qdiv_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QDIV) |-> (step_q < ntt_pkg::StepW'(ntt_pkg::QDivSteps)))
    else $error("octave division step out of range");

endmodule

### rtl/core/note_tuning_table_core.sv
// ----------------------------------------------------------------------------
// note_tuning_table_core
// per-note cents table with frequency lookup
//
// input channel (in_valid_i / in_stall_o) takes one transaction at a time.
// an update transaction (mode 0) writes cents_offset_i to the note and every
// octave above it, one table entry per cycle, and gives no result.
// a query transaction (mode 1) returns frequency_o (q16.16 hz) and
// cents_deviation_o after a table read, a 5 step octave division, then 24
// root multiply steps, each a multiply state and an accumulate state on the
// single 32x32 multiplier, a scale by 440 and rounding. the next transaction
// can be accepted in the cycle after the result is loaded.
// the result sits in an output register; while out_stall_i holds it there,
// the core keeps accepting and running updates, and a query waits in its last
// state until the register frees up.
// reset clears the table to equal temperament (valid bit per note, no sweep),
// the reference offset to zero and drops any pending result.
// cfg_wr_en_i / cfg_wr_data_i write the reference offset; the user must write it only while idle (unenforced).
// ----------------------------------------------------------------------------
module note_tuning_table_core #(
  parameter int NUM_NOTES = ntt_pkg::DefNumNotes
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [ntt_pkg::NoteW-1:0]         note_i,
  input  logic signed [ntt_pkg::CentsW-1:0] cents_offset_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ntt_pkg::FreqW-1:0]         frequency_o,
  output logic signed [ntt_pkg::CentsW-1:0] cents_deviation_o,
  input  logic                              cfg_wr_en_i,
  input  logic signed [ntt_pkg::CentsW-1:0] cfg_wr_data_i
);

  ntt_pkg::cmd_t cmd;
  ntt_pkg::sts_t sts;

  ntt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ntt_dpath #(
    .NUM_NOTES (NUM_NOTES)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .mode_i            (mode_i),
    .note_i            (note_i),
    .cents_offset_i    (cents_offset_i),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .frequency_o       (frequency_o),
    .cents_deviation_o (cents_deviation_o)
  );

endmodule

### tb/note_tuning_table_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_tuning_table_core_test
// self-checking testbench of the per-note tuning table
//
// drives update and query transactions through the valid/stall input channel
// and predicts every query result with a bit-true fixed-point model of the
// octave root chain. a directed set covers field extremes, octave propagation
// and equal temperament after reset; random phases follow, each under its own
// reference offset and one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module note_tuning_table_core_test;

  localparam int NumNotes      = 128;
  localparam int ItemsPerPhase = 205;
  localparam int SettleCycles  = 20;
  localparam int IdleLimit     = 3000;

  class tuning_scoreboard;
    typedef struct {
      logic [ntt_pkg::FreqW-1:0]         freq;
      logic signed [ntt_pkg::CentsW-1:0] dev;
    } tone_t;

    logic signed [ntt_pkg::CentsW-1:0] cents_tbl [NumNotes];
    logic signed [ntt_pkg::CentsW-1:0] ref_cents;
    logic [63:0]                       roots [24];
    tone_t                             pending_tones [$];
    int                                mismatches;

    function new();
      logic [63:0] r;
      r = 64'd2 << 31;
      for (int i = 0; i < 24; i++) begin
        r = floor_sqrt(r << 31);
        roots[i] = r;
      end
      foreach (cents_tbl[i]) cents_tbl[i] = '0;
      ref_cents  = '0;
      mismatches = 0;
    endfunction

    function logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] res;
      logic [63:0] trial;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = res | (64'd1 << b);
        if (trial * trial <= x) res = trial;
      end
      return res;
    endfunction

    // 440 * 2^(tc / 120000) in q16.16, tc in hundredths of a cent
    function logic [ntt_pkg::FreqW-1:0] predict_frequency(int tc);
      int          oct;
      int          rem;
      int          k;
      logic [63:0] frac;
      logic [63:0] acc;
      logic [63:0] m;
      oct = tc / 120000;
      rem = tc % 120000;
      if (rem < 0) begin
        rem += 120000;
        oct -= 1;
      end
      frac = (64'(rem) << 24) / 64'd120000;
      acc  = 64'd1 << 31;
      for (int i = 0; i < 24; i++) begin
        if (frac[23-i]) acc = (acc * roots[i] + (64'd1 << 30)) >> 31;
      end
      m = 64'd440 * acc;
      k = 15 - oct;
      if (k > 0) begin
        if (k >= 63) return '0;
        m = (m + (64'd1 << (k - 1))) >> k;
        return (m > 64'hFFFF_FFFF) ? '1 : m[ntt_pkg::FreqW-1:0];
      end
      if (-k >= 32) return (m == 0) ? '0 : '1;
      if (m > (64'hFFFF_FFFF >> (-k))) return '1;
      m = m << (-k);
      return m[ntt_pkg::FreqW-1:0];
    endfunction

    function void set_reference(logic signed [ntt_pkg::CentsW-1:0] v);
      ref_cents = v;
    endfunction

    function void note_input(logic mode, logic [ntt_pkg::NoteW-1:0] note,
                             logic signed [ntt_pkg::CentsW-1:0] cents);
      tone_t t;
      int    tc;
      if (mode == ntt_pkg::ModeUpdate) begin
        for (int n = int'(note); n < NumNotes; n += 12) cents_tbl[n] = cents;
      end else begin
        tc = (int'(note) - 69) * 10000 + int'(cents_tbl[note]) + int'(ref_cents);
        t.freq = predict_frequency(tc);
        t.dev  = cents_tbl[note];
        pending_tones.push_back(t);
      end
    endfunction

    function void check_result(logic [ntt_pkg::FreqW-1:0] freq,
                               logic signed [ntt_pkg::CentsW-1:0] dev);
      tone_t want;
      if (pending_tones.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result freq=%h dev=%0d", $realtime, freq, dev);
        return;
      end
      want = pending_tones.pop_front();
      if (freq !== want.freq || dev !== want.dev) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch freq exp=%h got=%h dev exp=%0d got=%0d",
                   $realtime, want.freq, freq, want.dev, dev);
      end
    endfunction

    function int pending();
      return pending_tones.size();
    endfunction
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic                              mode_i = ntt_pkg::ModeUpdate;
  logic [ntt_pkg::NoteW-1:0]         note_i = '0;
  logic signed [ntt_pkg::CentsW-1:0] cents_offset_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [ntt_pkg::FreqW-1:0]         frequency_o;
  logic signed [ntt_pkg::CentsW-1:0] cents_deviation_o;
  logic                              cfg_wr_en_i = 1'b0;
  logic signed [ntt_pkg::CentsW-1:0] cfg_wr_data_i = '0;

  tuning_scoreboard          sb;
  int                        send_idle_pct = 0;
  int                        recv_stall_pct = 0;
  int                        idle_cycles = 0;
  logic [ntt_pkg::NoteW-1:0] last_update_note = '0;

  note_tuning_table_core u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .note_i            (note_i),
    .cents_offset_i    (cents_offset_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .frequency_o       (frequency_o),
    .cents_deviation_o (cents_deviation_o),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // signals are stable mid-cycle, so a transaction seen here completes at the next edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(frequency_o, cents_deviation_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_item(input logic m, input logic [ntt_pkg::NoteW-1:0] n,
                           input logic signed [ntt_pkg::CentsW-1:0] c);
    logic hold;
    logic taken;
    hold = ($urandom_range(0, 63) == 0);
    if (hold || ($urandom_range(0, 99) < send_idle_pct)) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i);
      while (($urandom_range(0, 99) < send_idle_pct) || (hold && sb.pending() != 0));
    end
    in_valid_i     <= 1'b1;
    mode_i         <= m;
    note_i         <= n;
    cents_offset_i <= c;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (taken) sb.note_input(m, n, c);
      @(posedge clk_i);
    end
    if (m == ntt_pkg::ModeUpdate) last_update_note = n;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reference(input int v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= ntt_pkg::CentsW'(v);
    @(posedge clk_i);
    sb.set_reference(ntt_pkg::CentsW'(v));
    cfg_wr_en_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item();
    logic                              m;
    logic [ntt_pkg::NoteW-1:0]         n;
    logic signed [ntt_pkg::CentsW-1:0] c;
    int                                base;
    m = ($urandom_range(0, 99) < 45) ? ntt_pkg::ModeUpdate : ntt_pkg::ModeQuery;
    case ($urandom_range(0, 9))
      0: n = '0;
      1: n = 7'd127;
      default: n = ntt_pkg::NoteW'($urandom_range(0, 127));
    endcase
    // queries often land in the octave chain of the last update
    if (m == ntt_pkg::ModeQuery && $urandom_range(0, 9) < 4) begin
      base = int'(last_update_note) % 12;
      n = ntt_pkg::NoteW'(base + 12 * $urandom_range(0, (127 - base) / 12));
    end
    case ($urandom_range(0, 9))
      0: c = ntt_pkg::CentsW'(-131072);
      1: c = ntt_pkg::CentsW'(131071);
      2: c = ($urandom_range(0, 1) != 0) ? ntt_pkg::CentsW'(120000)
                                         : ntt_pkg::CentsW'(-120000);
      3, 4, 5: c = ntt_pkg::CentsW'(int'($urandom_range(0, 240000)) - 120000);
      6, 7: c = ntt_pkg::CentsW'(int'($urandom_range(0, 2000)) - 1000);
      default: c = ntt_pkg::CentsW'($urandom);
    endcase
    send_item(m, n, c);
  endtask

  initial begin
    int ref_vals [8];
    sb = new();
    ref_vals = '{-120000, 120000, -131072, 131071, 0, 0, 0, 37};
    ref_vals[5] = int'($urandom_range(0, 240000)) - 120000;
    ref_vals[6] = int'($signed(ntt_pkg::CentsW'($urandom)));
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // equal temperament after reset, then octave propagation and extremes
    send_item(ntt_pkg::ModeQuery,  7'd0,   '0);
    send_item(ntt_pkg::ModeQuery,  7'd69,  ntt_pkg::CentsW'(-1));
    send_item(ntt_pkg::ModeQuery,  7'd127, '0);
    send_item(ntt_pkg::ModeUpdate, 7'd0,   ntt_pkg::CentsW'(-131072));
    send_item(ntt_pkg::ModeQuery,  7'd0,   '0);
    send_item(ntt_pkg::ModeQuery,  7'd120, '0);
    send_item(ntt_pkg::ModeQuery,  7'd1,   '0);
    send_item(ntt_pkg::ModeUpdate, 7'd127, ntt_pkg::CentsW'(131071));
    send_item(ntt_pkg::ModeQuery,  7'd127, '0);
    send_item(ntt_pkg::ModeQuery,  7'd115, '0);
    send_item(ntt_pkg::ModeUpdate, 7'd11,  ntt_pkg::CentsW'(120000));
    send_item(ntt_pkg::ModeQuery,  7'd119, '0);
    send_item(ntt_pkg::ModeUpdate, 7'd116, ntt_pkg::CentsW'(-120000));
    send_item(ntt_pkg::ModeQuery,  7'd116, '0);
    send_item(ntt_pkg::ModeQuery,  7'd104, '0);
    send_item(ntt_pkg::ModeUpdate, 7'd69,  '0);
    send_item(ntt_pkg::ModeQuery,  7'd69,  '0);
    send_item(ntt_pkg::ModeUpdate, 7'd5,   ntt_pkg::CentsW'(18'h15555));
    send_item(ntt_pkg::ModeQuery,  7'd125, '0);
    send_item(ntt_pkg::ModeUpdate, 7'd6,   ntt_pkg::CentsW'(18'h2AAAA));
    send_item(ntt_pkg::ModeQuery,  7'd6,   '0);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_reference(ref_vals[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (ItemsPerPhase) random_item();
      drain();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/ntt_pkg.sv
rtl/core/ntt_ram.sv
rtl/core/ntt_dpath.sv
rtl/core/ntt_ctrl.sv
rtl/core/note_tuning_table_core.sv
tb/note_tuning_table_core_test.sv
